// ===== hw/rtl/mcwd_pkg.sv =====
`timescale 1ns / 1ps

package mcwd_pkg;

  // Major opcodes
  localparam logic [3:0] OP_REG    = 4'd0;
  localparam logic [3:0] OP_ADDI   = 4'd1;
  localparam logic [3:0] OP_LW     = 4'd2;
  localparam logic [3:0] OP_SW     = 4'd3;
  localparam logic [3:0] OP_BEQ    = 4'd4;
  localparam logic [3:0] OP_BNE    = 4'd5;
  localparam logic [3:0] OP_LUI    = 4'd6;
  localparam logic [3:0] OP_ORI    = 4'd7;
  localparam logic [3:0] OP_JALR   = 4'd8;
  localparam logic [3:0] OP_JMP    = 4'd9;
  localparam logic [3:0] OP_IN     = 4'd10;
  localparam logic [3:0] OP_OUT    = 4'd11;
  localparam logic [3:0] OP_HALT   = 4'd12;
  localparam logic [3:0] OP_SYS    = 4'd13;
  localparam logic [3:0] OP_SWP    = 4'd14;
  localparam logic [3:0] OP_EXT    = 4'd15;

  // Microsteps
  localparam logic [2:0] T0 = 3'd0;
  localparam logic [2:0] T1 = 3'd1;
  localparam logic [2:0] T2 = 3'd2;
  localparam logic [2:0] T3 = 3'd3;
  localparam logic [2:0] T4 = 3'd4;
  localparam logic [2:0] T5 = 3'd5;
  localparam logic [2:0] T6 = 3'd6;

  // Bus output enables (active low)
  localparam logic [7:0] B_PC  = 8'h01;
  localparam logic [7:0] B_RA  = 8'h02;
  localparam logic [7:0] B_RB  = 8'h04;
  localparam logic [7:0] B_ALU = 8'h08;
  localparam logic [7:0] B_RAM = 8'h10;
  localparam logic [7:0] B_ROM = 8'h20;
  localparam logic [7:0] B_IMM = 8'h40;
  localparam logic [7:0] B_IO  = 8'h80;

  // Load strobes
  localparam logic [7:0] L_PC    = 8'h01;
  localparam logic [7:0] L_REG   = 8'h02;
  localparam logic [7:0] L_MAR   = 8'h04;
  localparam logic [7:0] L_IR    = 8'h08;
  localparam logic [7:0] L_RAMWE = 8'h10;
  localparam logic [7:0] L_FLAGS = 8'h20;
  localparam logic [7:0] L_IO    = 8'h40;
  localparam logic [7:0] L_TMPA  = 8'h80;

  // ALU control byte
  localparam logic [7:0] A_TMPB   = 8'h01;
  localparam logic [7:0] A_PROGWE = 8'h02;
  localparam logic [7:0] A_SRC    = 8'h40;
  localparam logic [7:0] A_PCINC  = 8'h80;

  // Select byte
  localparam logic [7:0] S_PCAOUT = 8'h01;

  // Misc byte
  localparam logic [7:0] M_R7    = 8'h01;
  localparam logic [7:0] M_IELD  = 8'h02;
  localparam logic [7:0] M_IEVAL = 8'h04;
  localparam logic [7:0] M_HALT  = 8'h08;
  localparam logic [7:0] M_END   = 8'h10;
  localparam logic [7:0] M_IDLE  = 8'hE0;

  // Immediate modes
  localparam logic [2:0] IMM_6S  = 3'd0;
  localparam logic [2:0] IMM_8H  = 3'd1;
  localparam logic [2:0] IMM_12S = 3'd2;
  localparam logic [2:0] IMM_8Z  = 3'd3;
  localparam logic [2:0] IMM_VEC = 3'd4;

  // Operand selects
  localparam logic [1:0] SEL_RS  = 2'd0;
  localparam logic [1:0] SEL_RD  = 2'd1;
  localparam logic [1:0] SEL_R7  = 2'd2;
  localparam logic [1:0] SELB_RT = 2'd0;
  localparam logic [1:0] SELB_RD = 2'd1;
  localparam logic [1:0] SELB_RS = 2'd2;

  // Configuration register indexes
  localparam logic [2:0] REG_ALU_ADD   = 3'd0;
  localparam logic [2:0] REG_ALU_SUB   = 3'd1;
  localparam logic [2:0] REG_ALU_OR    = 3'd2;
  localparam logic [2:0] REG_SYS_EN    = 3'd3;
  localparam logic [2:0] REG_SYS_DIS   = 3'd4;
  localparam logic [2:0] REG_SYS_RET   = 3'd5;

  // Configuration reset values
  localparam logic [2:0] RST_ALU_ADD = 3'd0;
  localparam logic [2:0] RST_ALU_SUB = 3'd1;
  localparam logic [2:0] RST_ALU_OR  = 3'd3;
  localparam logic [2:0] RST_SYS_EN  = 3'd0;
  localparam logic [2:0] RST_SYS_DIS = 3'd1;
  localparam logic [2:0] RST_SYS_RET = 3'd2;

  typedef struct packed {
    logic [2:0] alu_add;
    logic [2:0] alu_sub;
    logic [2:0] alu_or;
    logic [2:0] sys_enable;
    logic [2:0] sys_disable;
    logic [2:0] sys_return;
  } cfg_t;

  typedef struct packed {
    logic [3:0] opcode;
    logic [2:0] funct;
    logic [2:0] step;
    logic       zero_flag;
    logic       irq_sampled;
    logic       irq_enable;
  } item_t;

  typedef struct packed {
    logic [7:0] bus_enable_byte;
    logic [7:0] load_byte;
    logic [7:0] alu_ctrl_byte;
    logic [7:0] select_byte;
    logic [7:0] misc_byte;
    logic       unreachable;
  } word_t;

endpackage

// ===== hw/rtl/mcwd_decode.sv =====
`timescale 1ns / 1ps

module mcwd_decode import mcwd_pkg::*; (
  input  cfg_t  cfg,
  input  item_t item,
  output word_t word
);

  function automatic logic [7:0] alu_bits(input logic [2:0] code);
    alu_bits = {3'b000, code, 2'b00};
  endfunction

  function automatic logic [7:0] imm_bits(input logic [2:0] mode);
    imm_bits = {4'b0000, mode, 1'b0};
  endfunction

  function automatic logic [7:0] sela_bits(input logic [1:0] s);
    sela_bits = {2'b00, s, 4'b0000};
  endfunction

  function automatic logic [7:0] selb_bits(input logic [1:0] s);
    selb_bits = {s, 6'b000000};
  endfunction

  logic [7:0] be;
  logic [7:0] ld;
  logic [7:0] ac;
  logic [7:0] sl;
  logic [7:0] ms;
  logic       hit;
  logic       taken;

  always_comb begin
    be    = 8'hFF;
    ld    = L_RAMWE;
    ac    = A_PROGWE;
    sl    = S_PCAOUT;
    ms    = M_IDLE;
    hit   = 1'b1;
    taken = (item.opcode == OP_BEQ) ? item.zero_flag : ~item.zero_flag;

    if (item.irq_sampled && item.irq_enable && (item.step == T0)) begin
      // interrupt entry: save PC into r7
      be = be & ~B_PC;
      ld = ld | L_REG;
      ms = ms | M_R7;
    end else if (item.irq_sampled && item.irq_enable && (item.step == T1)) begin
      // jump to vector, drop IE
      be = be & ~B_IMM;
      ld = ld | L_PC;
      sl = sl | imm_bits(IMM_VEC);
      ms = ms | M_IELD | M_END;
    end else if (item.step == T0) begin
      // fetch
      be = be & ~B_ROM;
      ld = ld | L_IR;
      ac = ac | A_PCINC;
      sl = sl & ~S_PCAOUT;
    end else begin
      unique case (item.opcode)
        OP_REG: begin
          if (item.step == T1) begin
            be = be & ~B_RA; ld = ld | L_TMPA; sl = sl | sela_bits(SEL_RS);
          end else if (item.step == T2) begin
            be = be & ~B_RB; ac = ac | A_TMPB; sl = sl | selb_bits(SELB_RT);
          end else if (item.step == T3) begin
            be = be & ~B_ALU; ld = ld | L_REG | L_FLAGS; ac = ac | A_SRC;
            ms = ms | M_END;
          end else begin
            hit = 1'b0;
          end
        end
        OP_ADDI, OP_ORI: begin
          if (item.step == T1) begin
            be = be & ~B_RA; ld = ld | L_TMPA;
            sl = sl | sela_bits((item.opcode == OP_ADDI) ? SEL_RS : SEL_RD);
          end else if (item.step == T2) begin
            be = be & ~B_IMM; ac = ac | A_TMPB;
            sl = sl | imm_bits((item.opcode == OP_ADDI) ? IMM_6S : IMM_8Z);
          end else if (item.step == T3) begin
            be = be & ~B_ALU; ld = ld | L_REG | L_FLAGS;
            ac = ac | alu_bits((item.opcode == OP_ADDI) ? cfg.alu_add : cfg.alu_or);
            ms = ms | M_END;
          end else begin
            hit = 1'b0;
          end
        end
        OP_LW, OP_SW, OP_SWP: begin
          if (item.step == T1) begin
            be = be & ~B_RA; ld = ld | L_TMPA; sl = sl | sela_bits(SEL_RS);
          end else if (item.step == T2) begin
            be = be & ~B_IMM; ac = ac | A_TMPB; sl = sl | imm_bits(IMM_6S);
          end else if (item.step == T3) begin
            be = be & ~B_ALU; ld = ld | L_MAR; ac = ac | alu_bits(cfg.alu_add);
          end else if (item.step == T4) begin
            if (item.opcode == OP_LW) begin
              be = be & ~B_RAM; ld = ld | L_REG;
            end else begin
              be = be & ~B_RB; sl = sl | selb_bits(SELB_RD);
              if (item.opcode == OP_SW) begin
                ld = ld & ~L_RAMWE;
              end else begin
                ac = ac & ~A_PROGWE;
              end
            end
            ms = ms | M_END;
          end else begin
            hit = 1'b0;
          end
        end
        OP_BEQ, OP_BNE: begin
          if (item.step == T1) begin
            be = be & ~B_RA; ld = ld | L_TMPA; sl = sl | sela_bits(SEL_RD);
          end else if (item.step == T2) begin
            be = be & ~B_RB; ac = ac | A_TMPB; sl = sl | selb_bits(SELB_RS);
          end else if (item.step == T3) begin
            be = be & ~B_ALU; ld = ld | L_FLAGS; ac = ac | alu_bits(cfg.alu_sub);
          end else if (!taken) begin
            // branch not taken ends cleanly at T4
            if (item.step == T4) begin
              be = be & ~B_ALU; ms = ms | M_END;
            end else begin
              hit = 1'b0;
            end
          end else if (item.step == T4) begin
            be = be & ~B_PC; ld = ld | L_TMPA;
          end else if (item.step == T5) begin
            be = be & ~B_IMM; ac = ac | A_TMPB; sl = sl | imm_bits(IMM_6S);
          end else if (item.step == T6) begin
            be = be & ~B_ALU; ld = ld | L_PC; ac = ac | alu_bits(cfg.alu_add);
            ms = ms | M_END;
          end else begin
            hit = 1'b0;
          end
        end
        OP_LUI: begin
          if (item.step == T1) begin
            be = be & ~B_IMM; ld = ld | L_REG; sl = sl | imm_bits(IMM_8H);
            ms = ms | M_END;
          end else begin
            hit = 1'b0;
          end
        end
        OP_JALR: begin
          if (item.step == T1) begin
            be = be & ~B_PC; ld = ld | L_REG;
          end else if (item.step == T2) begin
            be = be & ~B_RA; ld = ld | L_PC; sl = sl | sela_bits(SEL_RS);
            ms = ms | M_END;
          end else begin
            hit = 1'b0;
          end
        end
        OP_JMP: begin
          if (item.step == T1) begin
            be = be & ~B_PC; ld = ld | L_TMPA;
          end else if (item.step == T2) begin
            be = be & ~B_IMM; ac = ac | A_TMPB; sl = sl | imm_bits(IMM_12S);
          end else if (item.step == T3) begin
            be = be & ~B_ALU; ld = ld | L_PC; ac = ac | alu_bits(cfg.alu_add);
            ms = ms | M_END;
          end else begin
            hit = 1'b0;
          end
        end
        OP_IN, OP_OUT: begin
          if (item.step == T1) begin
            be = be & ~B_IMM; ld = ld | L_MAR; sl = sl | imm_bits(IMM_8Z);
          end else if (item.step == T2) begin
            if (item.opcode == OP_IN) begin
              be = be & ~B_IO; ld = ld | L_REG;
            end else begin
              be = be & ~B_RA; ld = ld | L_IO; sl = sl | sela_bits(SEL_RD);
            end
            ms = ms | M_END;
          end else begin
            hit = 1'b0;
          end
        end
        OP_HALT, OP_EXT: begin
          if (item.step == T1) begin
            be = be & ~B_ALU; ms = ms | M_END | M_HALT;
          end else begin
            hit = 1'b0;
          end
        end
        OP_SYS: begin
          if (item.step != T1) begin
            hit = 1'b0;
          end else if (item.funct == cfg.sys_enable) begin
            be = be & ~B_ALU; ms = ms | M_END | M_IELD | M_IEVAL;
          end else if (item.funct == cfg.sys_disable) begin
            be = be & ~B_ALU; ms = ms | M_END | M_IELD;
          end else if (item.funct == cfg.sys_return) begin
            be = be & ~B_RA; ld = ld | L_PC; sl = sl | sela_bits(SEL_R7);
            ms = ms | M_IELD | M_IEVAL | M_END;
          end else begin
            // reserved sub-function: plain idle-end
            be = be & ~B_ALU; ms = ms | M_END;
          end
        end
        default: begin
          hit = 1'b0;
        end
      endcase
    end

    if (!hit) begin
      // no sequence defined here: idle-end and flag it
      be = 8'hFF & ~B_ALU;
      ld = L_RAMWE;
      ac = A_PROGWE;
      sl = S_PCAOUT;
      ms = M_IDLE | M_END;
    end

    word.bus_enable_byte = be;
    word.load_byte       = ld;
    word.alu_ctrl_byte   = ac;
    word.select_byte     = sl;
    word.misc_byte       = ms;
    word.unreachable     = ~hit;
  end

endmodule

// ===== hw/rtl/microcode_control_word_decoder_core.sv =====
`timescale 1ns / 1ps

// Channel   Direction  Handshake          Contents
// in_*      input      in_valid/in_stall  opcode, funct, step, zero flag, irq, ie
// out_*     output     out_valid/out_stall five control bytes, unreachable flag
// apb       input      psel/penable/...   six 3-bit code registers at 4*i
//
// The item is captured in the input register, decoded by one pass of the
// control-store logic and captured in the result register. One item is taken
// every cycle while out_stall is low; the result register alone sets the rate.
// Reset clears both valid bits and loads the code registers with their defaults.
// A stalled result holds; the input register keeps filling while the result
// register drains, so the input side stalls only when both stages are full.

module microcode_control_word_decoder_core import mcwd_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,

  input  logic        in_valid,
  output logic        in_stall,
  input  logic [3:0]  in_opcode,
  input  logic [2:0]  in_funct,
  input  logic [2:0]  in_step,
  input  logic        in_zero_flag,
  input  logic        in_irq_sampled,
  input  logic        in_irq_enable,

  output logic        out_valid,
  input  logic        out_stall,
  output logic [7:0]  out_bus_enable_byte,
  output logic [7:0]  out_load_byte,
  output logic [7:0]  out_alu_ctrl_byte,
  output logic [7:0]  out_select_byte,
  output logic [7:0]  out_misc_byte,
  output logic        out_unreachable,

  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  cfg_t  cfg_r;
  item_t item_r;
  logic  s1_valid_r;
  word_t word_r;
  logic  out_valid_r;
  word_t dec_word;
  logic  s2_ready;
  logic  s1_load;
  logic  cfg_wr;
  logic [2:0] reg_idx;

  // Configuration registers: written on the APB access phase
  assign pready  = 1'b1;
  assign reg_idx = paddr[4:2];
  assign cfg_wr  = psel & penable & pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.alu_add     <= RST_ALU_ADD;
      cfg_r.alu_sub     <= RST_ALU_SUB;
      cfg_r.alu_or      <= RST_ALU_OR;
      cfg_r.sys_enable  <= RST_SYS_EN;
      cfg_r.sys_disable <= RST_SYS_DIS;
      cfg_r.sys_return  <= RST_SYS_RET;
    end else if (cfg_wr) begin
      unique case (reg_idx)
        REG_ALU_ADD: cfg_r.alu_add     <= pwdata[2:0];
        REG_ALU_SUB: cfg_r.alu_sub     <= pwdata[2:0];
        REG_ALU_OR:  cfg_r.alu_or      <= pwdata[2:0];
        REG_SYS_EN:  cfg_r.sys_enable  <= pwdata[2:0];
        REG_SYS_DIS: cfg_r.sys_disable <= pwdata[2:0];
        REG_SYS_RET: cfg_r.sys_return  <= pwdata[2:0];
        default: begin
          // unmapped address: drop the write
        end
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_ALU_ADD: prdata = {29'd0, cfg_r.alu_add};
      REG_ALU_SUB: prdata = {29'd0, cfg_r.alu_sub};
      REG_ALU_OR:  prdata = {29'd0, cfg_r.alu_or};
      REG_SYS_EN:  prdata = {29'd0, cfg_r.sys_enable};
      REG_SYS_DIS: prdata = {29'd0, cfg_r.sys_disable};
      REG_SYS_RET: prdata = {29'd0, cfg_r.sys_return};
      default:     prdata = 32'd0;
    endcase
  end

  // Flow control: the result register advances when empty or not stalled;
  // the input register advances when empty or when its item moves on.
  assign s2_ready = ~out_valid_r | ~out_stall;
  assign in_stall = s1_valid_r & ~s2_ready;
  assign s1_load  = ~s1_valid_r | s2_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (s1_load) begin
        s1_valid_r <= in_valid;
      end
      if (s2_ready) begin
        out_valid_r <= s1_valid_r;
      end
    end
  end

  // Input register: capture an accepted item
  always_ff @(posedge clk) begin
    if (s1_load && in_valid) begin
      item_r.opcode      <= in_opcode;
      item_r.funct       <= in_funct;
      item_r.step        <= in_step;
      item_r.zero_flag   <= in_zero_flag;
      item_r.irq_sampled <= in_irq_sampled;
      item_r.irq_enable  <= in_irq_enable;
    end
  end

  mcwd_decode u_decode (
    .cfg  (cfg_r),
    .item (item_r),
    .word (dec_word)
  );

  // Result register: hold while stalled
  always_ff @(posedge clk) begin
    if (s2_ready && s1_valid_r) begin
      word_r <= dec_word;
    end
  end

  assign out_valid           = out_valid_r;
  assign out_bus_enable_byte = word_r.bus_enable_byte;
  assign out_load_byte       = word_r.load_byte;
  assign out_alu_ctrl_byte   = word_r.alu_ctrl_byte;
  assign out_select_byte     = word_r.select_byte;
  assign out_misc_byte       = word_r.misc_byte;
  assign out_unreachable     = word_r.unreachable;

endmodule

// ===== dv/microcode_control_word_decoder_core_tb.sv =====
`timescale 1ns / 1ps

module microcode_control_word_decoder_core_tb;
  import mcwd_pkg::*;

  // Step 7 never has a sequence of its own; the package stops at T6.
  localparam logic [2:0] T7 = 3'd7;

  // Cycles without any handshake or register access before the run is abandoned.
  // The longest quiet stretch is a solid receiver stall plus a sender gap plus
  // the drain and register writes between phases.
  localparam int IDLE_LIMIT = 2000;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;

  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [3:0]  in_opcode = '0;
  logic [2:0]  in_funct = '0;
  logic [2:0]  in_step = '0;
  logic        in_zero_flag = 1'b0;
  logic        in_irq_sampled = 1'b0;
  logic        in_irq_enable = 1'b0;

  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [7:0]  out_bus_enable_byte;
  logic [7:0]  out_load_byte;
  logic [7:0]  out_alu_ctrl_byte;
  logic [7:0]  out_select_byte;
  logic [7:0]  out_misc_byte;
  logic        out_unreachable;

  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [4:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  microcode_control_word_decoder_core DUT (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_valid            (in_valid),
    .in_stall            (in_stall),
    .in_opcode           (in_opcode),
    .in_funct            (in_funct),
    .in_step             (in_step),
    .in_zero_flag        (in_zero_flag),
    .in_irq_sampled      (in_irq_sampled),
    .in_irq_enable       (in_irq_enable),
    .out_valid           (out_valid),
    .out_stall           (out_stall),
    .out_bus_enable_byte (out_bus_enable_byte),
    .out_load_byte       (out_load_byte),
    .out_alu_ctrl_byte   (out_alu_ctrl_byte),
    .out_select_byte     (out_select_byte),
    .out_misc_byte       (out_misc_byte),
    .out_unreachable     (out_unreachable),
    .psel                (psel),
    .penable             (penable),
    .pwrite              (pwrite),
    .paddr               (paddr),
    .pwdata              (pwdata),
    .prdata              (prdata),
    .pready              (pready)
  );

  // Control-store addresses waiting to be driven, and control words the block owes us.
  item_t addr_queue[$];
  word_t word_queue[$];

  // Our copy of the code registers; changed only while the block is idle.
  cfg_t  code_regs = '{RST_ALU_ADD, RST_ALU_SUB, RST_ALU_OR,
                       RST_SYS_EN, RST_SYS_DIS, RST_SYS_RET};

  int    err_count = 0;
  int    idle_cycles = 0;
  bit    in_taken = 1'b0;

  // Sender burst state and receiver stall pattern state.
  item_t cur_addr;
  int    burst_left = 0;
  int    gap_left = 0;
  int    stall_mode = 0;
  int    stall_left = 0;

  initial begin
    forever #5 clk = ~clk;
  end

  // Decode one control-store address into the five control bytes.
  // Start from the blank word: every enable released, RAM and program writes
  // held off, PC off the address bus, unused misc bits high.
  function automatic word_t decode_word(item_t a, cfg_t c);
    logic [7:0] be;
    logic [7:0] ld;
    logic [7:0] ac;
    logic [7:0] sl;
    logic [7:0] ms;
    logic       defined;
    logic       taken;
    word_t      w;
    be = 8'hFF;
    ld = L_RAMWE;
    ac = A_PROGWE;
    sl = S_PCAOUT;
    ms = M_IDLE;
    defined = 1'b1;
    if (a.irq_sampled && a.irq_enable && a.step <= T1) begin
      // Interrupt entry: save PC into r7, then jump through the vector.
      if (a.step == T0) begin
        be &= ~B_PC; ld |= L_REG; ms |= M_R7;
      end else begin
        be &= ~B_IMM; ld |= L_PC; sl |= {4'b0, IMM_VEC, 1'b0}; ms |= M_IELD | M_END;
      end
    end else if (a.step == T0) begin
      // Fetch: ROM onto the bus, load IR, bump PC, PC drives the address.
      be &= ~B_ROM; ld |= L_IR; ac |= A_PCINC; sl &= ~S_PCAOUT;
    end else begin
      case (a.opcode)
        OP_REG: begin
          if (a.step == T1) begin
            be &= ~B_RA; ld |= L_TMPA; sl |= {2'b0, SEL_RS, 4'b0};
          end else if (a.step == T2) begin
            be &= ~B_RB; ac |= A_TMPB; sl |= {SELB_RT, 6'b0};
          end else if (a.step == T3) begin
            // Result step takes its function from the instruction: op code stays 0.
            be &= ~B_ALU; ld |= L_REG | L_FLAGS; ac |= A_SRC; ms |= M_END;
          end else begin
            defined = 1'b0;
          end
        end
        OP_ADDI, OP_ORI: begin
          if (a.step == T1) begin
            be &= ~B_RA; ld |= L_TMPA;
            sl |= {2'b0, (a.opcode == OP_ADDI) ? SEL_RS : SEL_RD, 4'b0};
          end else if (a.step == T2) begin
            be &= ~B_IMM; ac |= A_TMPB;
            sl |= {4'b0, (a.opcode == OP_ADDI) ? IMM_6S : IMM_8Z, 1'b0};
          end else if (a.step == T3) begin
            be &= ~B_ALU; ld |= L_REG | L_FLAGS;
            ac |= {3'b0, (a.opcode == OP_ADDI) ? c.alu_add : c.alu_or, 2'b0};
            ms |= M_END;
          end else begin
            defined = 1'b0;
          end
        end
        OP_LW, OP_SW, OP_SWP: begin
          if (a.step == T1) begin
            be &= ~B_RA; ld |= L_TMPA; sl |= {2'b0, SEL_RS, 4'b0};
          end else if (a.step == T2) begin
            be &= ~B_IMM; ac |= A_TMPB; sl |= {4'b0, IMM_6S, 1'b0};
          end else if (a.step == T3) begin
            be &= ~B_ALU; ld |= L_MAR; ac |= {3'b0, c.alu_add, 2'b0};
          end else if (a.step == T4) begin
            if (a.opcode == OP_LW) begin
              be &= ~B_RAM; ld |= L_REG;
            end else begin
              be &= ~B_RB; sl |= {SELB_RD, 6'b0};
              if (a.opcode == OP_SW) ld &= ~L_RAMWE;
              else ac &= ~A_PROGWE;
            end
            ms |= M_END;
          end else begin
            defined = 1'b0;
          end
        end
        OP_BEQ, OP_BNE: begin
          taken = (a.opcode == OP_BEQ) ? a.zero_flag : !a.zero_flag;
          if (a.step == T1) begin
            be &= ~B_RA; ld |= L_TMPA; sl |= {2'b0, SEL_RD, 4'b0};
          end else if (a.step == T2) begin
            be &= ~B_RB; ac |= A_TMPB; sl |= {SELB_RS, 6'b0};
          end else if (a.step == T3) begin
            be &= ~B_ALU; ld |= L_FLAGS; ac |= {3'b0, c.alu_sub, 2'b0};
          end else if (!taken) begin
            // Not taken ends cleanly at T4; anything later has no sequence.
            if (a.step == T4) begin
              be &= ~B_ALU; ms |= M_END;
            end else begin
              defined = 1'b0;
            end
          end else if (a.step == T4) begin
            be &= ~B_PC; ld |= L_TMPA;
          end else if (a.step == T5) begin
            be &= ~B_IMM; ac |= A_TMPB; sl |= {4'b0, IMM_6S, 1'b0};
          end else if (a.step == T6) begin
            be &= ~B_ALU; ld |= L_PC; ac |= {3'b0, c.alu_add, 2'b0}; ms |= M_END;
          end else begin
            defined = 1'b0;
          end
        end
        OP_LUI: begin
          if (a.step == T1) begin
            be &= ~B_IMM; ld |= L_REG; sl |= {4'b0, IMM_8H, 1'b0}; ms |= M_END;
          end else begin
            defined = 1'b0;
          end
        end
        OP_JALR: begin
          if (a.step == T1) begin
            be &= ~B_PC; ld |= L_REG;
          end else if (a.step == T2) begin
            be &= ~B_RA; ld |= L_PC; sl |= {2'b0, SEL_RS, 4'b0}; ms |= M_END;
          end else begin
            defined = 1'b0;
          end
        end
        OP_JMP: begin
          if (a.step == T1) begin
            be &= ~B_PC; ld |= L_TMPA;
          end else if (a.step == T2) begin
            be &= ~B_IMM; ac |= A_TMPB; sl |= {4'b0, IMM_12S, 1'b0};
          end else if (a.step == T3) begin
            be &= ~B_ALU; ld |= L_PC; ac |= {3'b0, c.alu_add, 2'b0}; ms |= M_END;
          end else begin
            defined = 1'b0;
          end
        end
        OP_IN, OP_OUT: begin
          if (a.step == T1) begin
            be &= ~B_IMM; ld |= L_MAR; sl |= {4'b0, IMM_8Z, 1'b0};
          end else if (a.step == T2) begin
            if (a.opcode == OP_IN) begin
              be &= ~B_IO; ld |= L_REG;
            end else begin
              be &= ~B_RA; ld |= L_IO; sl |= {2'b0, SEL_RD, 4'b0};
            end
            ms |= M_END;
          end else begin
            defined = 1'b0;
          end
        end
        OP_HALT, OP_EXT: begin
          if (a.step == T1) begin
            be &= ~B_ALU; ms |= M_END | M_HALT;
          end else begin
            defined = 1'b0;
          end
        end
        OP_SYS: begin
          // Coinciding codes: enable wins over disable, disable over return.
          if (a.step != T1) begin
            defined = 1'b0;
          end else if (a.funct == c.sys_enable) begin
            be &= ~B_ALU; ms |= M_END | M_IELD | M_IEVAL;
          end else if (a.funct == c.sys_disable) begin
            be &= ~B_ALU; ms |= M_END | M_IELD;
          end else if (a.funct == c.sys_return) begin
            be &= ~B_RA; ld |= L_PC; sl |= {2'b0, SEL_R7, 4'b0};
            ms |= M_IELD | M_IEVAL | M_END;
          end else begin
            // Reserved sub-function: plain idle-end, still a defined state.
            be &= ~B_ALU; ms |= M_END;
          end
        end
        default: defined = 1'b0;
      endcase
    end
    if (!defined) begin
      be = 8'hFF & ~B_ALU;
      ld = L_RAMWE;
      ac = A_PROGWE;
      sl = S_PCAOUT;
      ms = M_IDLE | M_END;
    end
    w.bus_enable_byte = be;
    w.load_byte       = ld;
    w.alu_ctrl_byte   = ac;
    w.select_byte     = sl;
    w.misc_byte       = ms;
    w.unreachable     = !defined;
    return w;
  endfunction

  function automatic item_t make_addr(logic [3:0] op, logic [2:0] fn, logic [2:0] st,
                                      logic z, logic irq, logic ie);
    item_t a;
    a.opcode      = op;
    a.funct       = fn;
    a.step        = st;
    a.zero_flag   = z;
    a.irq_sampled = irq;
    a.irq_enable  = ie;
    return a;
  endfunction

  task automatic report_mismatch(input string msg);
    $display("%0t ns mismatch: %s", $time, msg);
    err_count++;
  endtask

  // Write one code register through the APB port: setup cycle, then access cycle.
  task automatic write_code(input logic [2:0] idx, input logic [2:0] val);
    logic [31:0] data;
    data = $urandom();
    data[2:0] = val;
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= data;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    case (idx)
      REG_ALU_ADD: code_regs.alu_add     = val;
      REG_ALU_SUB: code_regs.alu_sub     = val;
      REG_ALU_OR:  code_regs.alu_or      = val;
      REG_SYS_EN:  code_regs.sys_enable  = val;
      REG_SYS_DIS: code_regs.sys_disable = val;
      REG_SYS_RET: code_regs.sys_return  = val;
      default: ;
    endcase
  endtask

  task automatic write_all_codes(input cfg_t c);
    write_code(REG_ALU_ADD, c.alu_add);
    write_code(REG_ALU_SUB, c.alu_sub);
    write_code(REG_ALU_OR,  c.alu_or);
    write_code(REG_SYS_EN,  c.sys_enable);
    write_code(REG_SYS_DIS, c.sys_disable);
    write_code(REG_SYS_RET, c.sys_return);
  endtask

  // Hold until every address is driven and every control word is back, then let
  // the two pipeline stages settle before touching the registers.
  task automatic wait_idle();
    do @(negedge clk);
    while (addr_queue.size() != 0 || in_valid || word_queue.size() != 0);
    repeat (4) @(negedge clk);
  endtask

  // Mostly whole instruction walks (T0 upward, fixed opcode, funct and flag),
  // the rest fully random addresses.
  task automatic queue_walks(input int n);
    int          added;
    int          last;
    logic [12:0] raw;
    logic [3:0]  op;
    logic [2:0]  fn;
    logic        z;
    logic        irq;
    logic        ie;
    added = 0;
    while (added < n) begin
      if ($urandom_range(0, 4) == 0) begin
        raw = 13'($urandom());
        addr_queue.push_back(raw);
        added++;
      end else begin
        op = 4'($urandom_range(0, 15));
        case ($urandom_range(0, 3))
          0: fn = code_regs.sys_enable;
          1: fn = code_regs.sys_disable;
          2: fn = code_regs.sys_return;
          default: fn = 3'($urandom_range(0, 7));
        endcase
        z    = 1'($urandom_range(0, 1));
        last = $urandom_range(1, 7);
        for (int s = 0; s <= last; s++) begin
          irq = ($urandom_range(0, 5) == 0);
          ie  = 1'($urandom_range(0, 1));
          addr_queue.push_back(make_addr(op, fn, s[2:0], z, irq, ie));
          added++;
        end
      end
    end
  endtask

  // Sender: advance to the next address once the current one is taken, in bursts
  // of random length separated by random gaps.
  always @(negedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_taken) begin
      if (gap_left > 0) begin
        gap_left--;
        in_valid <= 1'b0;
      end else if (addr_queue.size() == 0) begin
        in_valid <= 1'b0;
      end else begin
        cur_addr = addr_queue.pop_front();
        in_valid       <= 1'b1;
        in_opcode      <= cur_addr.opcode;
        in_funct       <= cur_addr.funct;
        in_step        <= cur_addr.step;
        in_zero_flag   <= cur_addr.zero_flag;
        in_irq_sampled <= cur_addr.irq_sampled;
        in_irq_enable  <= cur_addr.irq_enable;
        if (burst_left <= 1) begin
          burst_left = $urandom_range(1, 24);
          gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
        end else begin
          burst_left--;
        end
      end
    end
  end

  // Receiver: switch between no stall, random stall, solid stall and toggling.
  always @(negedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (stall_left == 0) begin
        stall_mode = $urandom_range(0, 3);
        stall_left = (stall_mode == 2) ? $urandom_range(1, 30) : $urandom_range(4, 60);
      end
      stall_left--;
      case (stall_mode)
        0: out_stall <= 1'b0;
        1: out_stall <= ($urandom_range(0, 99) < 40);
        2: out_stall <= 1'b1;
        default: out_stall <= ~out_stall;
      endcase
    end
  end

  // Monitor: predict on every accepted address, check every accepted word.
  always @(posedge clk) begin
    word_t want;
    in_taken = rst_n && in_valid && !in_stall;
    if (in_taken) begin
      word_queue.push_back(decode_word(make_addr(in_opcode, in_funct, in_step,
                                                 in_zero_flag, in_irq_sampled,
                                                 in_irq_enable), code_regs));
    end
    if (rst_n && out_valid && !out_stall) begin
      if (word_queue.size() == 0) begin
        report_mismatch("control word with nothing outstanding");
      end else begin
        want = word_queue.pop_front();
        if (out_bus_enable_byte !== want.bus_enable_byte)
          report_mismatch($sformatf("bus_enable_byte got %h want %h",
                                    out_bus_enable_byte, want.bus_enable_byte));
        if (out_load_byte !== want.load_byte)
          report_mismatch($sformatf("load_byte got %h want %h",
                                    out_load_byte, want.load_byte));
        if (out_alu_ctrl_byte !== want.alu_ctrl_byte)
          report_mismatch($sformatf("alu_ctrl_byte got %h want %h",
                                    out_alu_ctrl_byte, want.alu_ctrl_byte));
        if (out_select_byte !== want.select_byte)
          report_mismatch($sformatf("select_byte got %h want %h",
                                    out_select_byte, want.select_byte));
        if (out_misc_byte !== want.misc_byte)
          report_mismatch($sformatf("misc_byte got %h want %h",
                                    out_misc_byte, want.misc_byte));
        if (out_unreachable !== want.unreachable)
          report_mismatch($sformatf("unreachable got %b want %b",
                                    out_unreachable, want.unreachable));
      end
    end
  end

  // Watchdog: any handshake or register access restarts the count.
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || psel) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    cfg_t        c;
    logic [17:0] raw_cfg;

    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed pass under the reset codes.
    // Fetch with every other field but the interrupt request at its top value, interrupt
    // entry at both steps, and an interrupt request that is masked.
    addr_queue.push_back(make_addr(OP_EXT,    3'd7, T0, 1'b1, 1'b0, 1'b1));
    addr_queue.push_back(make_addr(OP_REG,    3'd0, T0, 1'b0, 1'b1, 1'b1));
    addr_queue.push_back(make_addr(OP_EXT,    3'd7, T1, 1'b1, 1'b1, 1'b1));
    addr_queue.push_back(make_addr(OP_REG,    3'd0, T0, 1'b0, 1'b1, 1'b0));
    // R-type result step and the step past its end.
    addr_queue.push_back(make_addr(OP_REG,    3'd0, T3, 1'b0, 1'b0, 1'b0));
    addr_queue.push_back(make_addr(OP_REG,    3'd0, T4, 1'b0, 1'b0, 1'b0));
    // Branch not taken ends at T4; later steps have no sequence. Also a taken T6 and a T3.
    addr_queue.push_back(make_addr(OP_BEQ,    3'd0, T4, 1'b0, 1'b0, 1'b0));
    addr_queue.push_back(make_addr(OP_BEQ,    3'd0, T5, 1'b0, 1'b0, 1'b0));
    addr_queue.push_back(make_addr(OP_BNE,    3'd0, T4, 1'b1, 1'b0, 1'b0));
    addr_queue.push_back(make_addr(OP_BEQ,    3'd0, T6, 1'b1, 1'b0, 1'b0));
    addr_queue.push_back(make_addr(OP_BNE,    3'd0, T3, 1'b0, 1'b0, 1'b0));
    // SYS: enable, disable, return, a reserved code, and a step with no sequence.
    addr_queue.push_back(make_addr(OP_SYS, RST_SYS_EN,  T1, 1'b0, 1'b0, 1'b0));
    addr_queue.push_back(make_addr(OP_SYS, RST_SYS_DIS, T1, 1'b0, 1'b0, 1'b0));
    addr_queue.push_back(make_addr(OP_SYS, RST_SYS_RET, T1, 1'b0, 1'b0, 1'b0));
    addr_queue.push_back(make_addr(OP_SYS,    3'd7, T1, 1'b0, 1'b0, 1'b0));
    addr_queue.push_back(make_addr(OP_SYS,    3'd0, T2, 1'b0, 1'b0, 1'b0));
    // Prefix and halt, the last step of every remaining opcode but ADDI, then R-type at step 7.
    addr_queue.push_back(make_addr(OP_EXT,    3'd0, T1, 1'b0, 1'b0, 1'b0));
    addr_queue.push_back(make_addr(OP_HALT,   3'd0, T1, 1'b0, 1'b0, 1'b0));
    addr_queue.push_back(make_addr(OP_LW,     3'd0, T4, 1'b0, 1'b0, 1'b0));
    addr_queue.push_back(make_addr(OP_SW,     3'd0, T4, 1'b0, 1'b0, 1'b0));
    addr_queue.push_back(make_addr(OP_SWP,    3'd0, T4, 1'b0, 1'b0, 1'b0));
    addr_queue.push_back(make_addr(OP_ORI,    3'd0, T3, 1'b0, 1'b0, 1'b0));
    addr_queue.push_back(make_addr(OP_LUI,    3'd0, T1, 1'b0, 1'b0, 1'b0));
    addr_queue.push_back(make_addr(OP_JALR,   3'd0, T2, 1'b0, 1'b0, 1'b0));
    addr_queue.push_back(make_addr(OP_JMP,    3'd0, T3, 1'b0, 1'b0, 1'b0));
    addr_queue.push_back(make_addr(OP_IN,     3'd0, T2, 1'b0, 1'b0, 1'b0));
    addr_queue.push_back(make_addr(OP_OUT,    3'd0, T2, 1'b0, 1'b0, 1'b0));
    addr_queue.push_back(make_addr(OP_REG,    3'd7, T7, 1'b1, 1'b0, 1'b0));

    // Random phases, each under its own register setting.
    for (int ph = 0; ph < 8; ph++) begin
      wait_idle();
      case (ph)
        0: c = '0;                      // all codes coincide at zero
        1: c = '1;                      // all codes at the top value
        2: begin                        // disable and return coincide
          raw_cfg = 18'($urandom());
          c = raw_cfg;
          c.sys_enable  = 3'd5;
          c.sys_disable = 3'd2;
          c.sys_return  = 3'd2;
        end
        7: c = '{RST_ALU_ADD, RST_ALU_SUB, RST_ALU_OR,
                 RST_SYS_EN, RST_SYS_DIS, RST_SYS_RET};
        default: begin
          raw_cfg = 18'($urandom());
          c = raw_cfg;
        end
      endcase
      write_all_codes(c);
      queue_walks(65);
    end

    wait_idle();
    repeat (6) @(posedge clk);
    if (err_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

// ===== files.f =====
hw/rtl/mcwd_pkg.sv
hw/rtl/mcwd_decode.sv
hw/rtl/microcode_control_word_decoder_core.sv
dv/microcode_control_word_decoder_core_tb.sv
